// ===== rtl/ntm_pkg.sv =====
// ----------------------------------------------------------------------------
// ntm_pkg
// shared types, constants and tables for the nontwist map step unit
// ----------------------------------------------------------------------------
package ntm_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int ITER_W       = $clog2(CORDIC_STEPS + 1);

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_FORWARD = 2'd1;
    localparam logic [1:0] OP_INVERSE = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [0:0] REG_TWIST = 1'b0;
    localparam logic [0:0] REG_KICK  = 1'b1;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_KICK,
        S_SQUARE,
        S_TWIST,
        S_TWIST_HI,
        S_DONE
    } t_state;

    // atan(2^-i) in units of 2^-32 revolution
    function automatic logic signed [33:0] atan_rev(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ntm_cordic.sv =====
// ----------------------------------------------------------------------------
// ntm_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle, sin(2*pi*x)
// ----------------------------------------------------------------------------
module ntm_cordic import ntm_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [FRAC_BITS-1:0] i_angle,
    output logic                        o_done,
    output logic signed [FRAC_BITS+1:0] o_sine
);
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [33:0] n_x, n_y, n_z;
    logic [ITER_W-1:0]  r_iter, n_iter;
    logic               r_busy, n_busy;
    logic signed [33:0] z0, dx, dy, s_round, s_shift;
    logic signed [33:0] one_q;

    always_comb begin
        z0 = 34'(i_angle) <<< (32 - FRAC_BITS);
        if (z0 >= 34'sd1073741824) begin
            z0 = 34'sd2147483648 - z0;
        end else if (z0 < -34'sd1073741824) begin
            z0 = -34'sd2147483648 - z0;
        end
        dx = r_y >>> r_iter;
        dy = r_x >>> r_iter;
        n_x = r_x; n_y = r_y; n_z = r_z; n_iter = r_iter; n_busy = r_busy;
        if (i_start) begin
            n_x = CORDIC_GAIN_Q30; n_y = '0; n_z = z0;
            n_iter = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                n_x = r_x - dx; n_y = r_y + dy; n_z = r_z - atan_rev(5'(r_iter));
            end else begin
                n_x = r_x + dx; n_y = r_y - dy; n_z = r_z + atan_rev(5'(r_iter));
            end
            n_iter = r_iter + 1'b1;
            if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_iter <= n_iter;
        end
        r_x <= n_x; r_y <= n_y; r_z <= n_z;
    end

    // round half up to the output grid and clamp to [-1,1]
    always_comb begin
        one_q   = 34'sd1 <<< FRAC_BITS;
        s_round = r_y + (34'sd1 <<< (29 - FRAC_BITS));
        s_shift = s_round >>> (30 - FRAC_BITS);
        if (s_shift > one_q) begin
            s_shift = one_q;
        end else if (s_shift < -one_q) begin
            s_shift = -one_q;
        end
    end

    assign o_sine = s_shift[FRAC_BITS+1:0];
    assign o_done = r_busy && (r_iter == ITER_W'(CORDIC_STEPS - 1));
endmodule

// ===== rtl/ntm_mul.sv =====
// ----------------------------------------------------------------------------
// ntm_mul
// shared registered unsigned 33x33 multiplier
// ----------------------------------------------------------------------------
module ntm_mul import ntm_pkg::*; (
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    output logic [65:0] o_p
);
    logic [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// ===== rtl/nontwist_map_step_unit.sv =====
// ----------------------------------------------------------------------------
// nontwist_map_step_unit
// standard nontwist map iterator, Q.24 fixed point
// ----------------------------------------------------------------------------
// A forward item runs the iterative cordic (one micro-rotation per cycle, the
// dominant cost), then four passes through one shared registered 33x33
// multiplier for b*sin, y^2 and the low and high halves of a*(1-y^2), each
// pass with its own update step, then the done state raises the result. An
// inverse item does the same work plus a launch step that starts the cordic
// on the freshly twisted angle. A load item or an unused op goes straight
// to the done state. The block takes no new item until the result has been
// transferred out; the result sits in an output register.
// Inverse steps run the twist first and the kick last, so the multiplier
// order is y^2, a*(1-y^2), cordic, b*sin. Configuration writes are taken
// at any time and must only come while the block is idle.
module nontwist_map_step_unit import ntm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_init_angle,
    input  logic signed [31:0] i_init_action,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_angle_out,
    output logic signed [31:0] o_action_out,
    output logic signed [47:0] o_lift_out,
    output logic               o_saturated
);
    localparam logic signed [47:0] LIFT_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] LIFT_MIN = {1'b1, {47{1'b0}}};

    t_state r_state, n_state;
    logic signed [31:0]          r_a, r_b;
    logic signed [FRAC_BITS-1:0] r_angle, n_angle;
    logic signed [31:0]          r_action, n_action;
    logic signed [47:0]          r_lift, n_lift;
    logic                        r_sat, n_sat;
    logic                        r_inv, n_inv;
    logic                        r_kicked, n_kicked;   // kick phase done
    logic                        r_twisted, n_twisted; // twist phase done
    logic                        r_wait, n_wait;       // multiplier latency
    logic signed [39:0]          r_w, n_w;             // 1-y^2, up to 2^38
    logic [65:0]                 r_plo, n_plo;         // low half of a*(1-y^2)
    logic                        r_valid, n_valid;
    logic                        cordic_start, cordic_done;
    logic signed [FRAC_BITS+1:0] sine;
    logic [32:0]                 mul_a, mul_b;
    logic [65:0]                 mul_p;

    logic signed [34:0] sine_ext;
    logic               kneg, tneg;
    logic [66:0]        kprod;
    logic [71:0]        tprod, tq;
    logic signed [67:0] kval, ny;
    logic [31:0]        uy;
    logic [38:0]        uw;
    logic [65:0]        y2;
    logic [FRAC_BITS-1:0] frac;
    logic signed [49:0] nl;

    ntm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (r_angle),
        .o_done  (cordic_done),
        .o_sine  (sine)
    );

    ntm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a <= '0; r_b <= '0;
            r_angle <= '0; r_action <= '0; r_lift <= '0;
            r_valid <= 1'b0; r_wait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_angle <= n_angle; r_action <= n_action; r_lift <= n_lift;
            r_valid <= n_valid; r_wait <= n_wait;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_TWIST) begin
                    r_a <= i_cfg_data;
                end else begin
                    r_b <= i_cfg_data;
                end
            end
        end
        r_sat <= n_sat; r_inv <= n_inv; r_kicked <= n_kicked;
        r_twisted <= n_twisted; r_w <= n_w; r_plo <= n_plo;
    end

    // magnitude operands for the shared multiplier
    always_comb begin
        sine_ext = 35'(sine);
        uy = r_action[31] ? 32'(-r_action) : r_action;
        uw = r_w[39] ? 39'(-r_w) : 39'(r_w);
        mul_a = '0; mul_b = '0;
        case (r_state)
            S_KICK: begin
                mul_a = r_b[31] ? 33'(-34'(r_b)) : 33'(r_b);
                mul_b = sine_ext[34] ? 33'(-sine_ext) : 33'(sine_ext);
            end
            S_SQUARE: begin
                mul_a = {1'b0, uy}; mul_b = {1'b0, uy};
            end
            S_TWIST: begin
                mul_a = r_a[31] ? 33'(-34'(r_a)) : 33'(r_a);
                mul_b = {1'b0, uw[31:0]};
            end
            S_TWIST_HI: begin
                mul_a = r_a[31] ? 33'(-34'(r_a)) : 33'(r_a);
                mul_b = {26'd0, uw[38:32]};
            end
            default: begin
                mul_a = '0; mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state; n_angle = r_angle; n_action = r_action; n_lift = r_lift;
        n_sat = r_sat; n_inv = r_inv; n_kicked = r_kicked; n_twisted = r_twisted;
        n_wait = 1'b0; n_w = r_w; n_plo = r_plo; n_valid = r_valid;
        cordic_start = 1'b0;
        o_ready = 1'b0;
        // kick value, signed b*sin rounded half up
        kneg  = r_b[31] ^ sine[FRAC_BITS+1];
        kprod = {1'b0, mul_p};
        kval  = kneg ? -68'(kprod) : 68'(kprod);
        kval  = (kval + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        ny    = r_inv ? 68'(r_action) + kval : 68'(r_action) - kval;
        y2    = (mul_p + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        // twist magnitude from both halves, rounded half away from zero
        tneg  = (r_a[31] ^ r_w[39]) ^ r_inv;
        tprod = 72'(r_plo) + (72'(mul_p) << 32);
        tq    = (tprod + (72'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        frac  = tneg ? FRAC_BITS'(-tq[FRAC_BITS-1:0]) : tq[FRAC_BITS-1:0];
        nl    = tneg ? 50'(r_lift) - 50'(tq) : 50'(r_lift) + 50'(tq);
        case (r_state)
            S_IDLE: begin
                o_ready = !r_valid;
                if (i_valid && !r_valid) begin
                    n_sat = 1'b0; n_kicked = 1'b0; n_twisted = 1'b0;
                    n_inv = (i_op == OP_INVERSE);
                    if (i_op == OP_LOAD) begin
                        n_angle  = i_init_angle[FRAC_BITS-1:0];
                        n_action = i_init_action;
                        n_lift   = 48'(signed'(i_init_angle[FRAC_BITS-1:0]));
                        n_state  = S_DONE;
                    end else if (i_op == OP_FORWARD) begin
                        cordic_start = 1'b1;
                        n_state = S_CORDIC;
                    end else if (i_op == OP_INVERSE) begin
                        n_state = S_SQUARE; n_wait = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CORDIC: begin
                // launch cycle after a twist, angle register now up to date
                if (r_wait) begin
                    cordic_start = 1'b1;
                end else if (cordic_done) begin
                    n_state = S_KICK; n_wait = 1'b1;
                end
            end
            S_KICK: begin
                if (!r_wait) begin
                    n_kicked = 1'b1;
                    if (ny > 68'sd2147483647) begin
                        n_action = 32'h7fffffff; n_sat = 1'b1;
                    end else if (ny < -68'sd2147483648) begin
                        n_action = 32'h80000000; n_sat = 1'b1;
                    end else begin
                        n_action = ny[31:0];
                    end
                    if (r_twisted) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SQUARE; n_wait = 1'b1;
                    end
                end
            end
            S_SQUARE: begin
                if (!r_wait) begin
                    n_w = (40'sd1 <<< FRAC_BITS) - 40'(y2);
                    n_state = S_TWIST; n_wait = 1'b1;
                end
            end
            S_TWIST: begin
                if (!r_wait) begin
                    n_plo = mul_p;
                    n_state = S_TWIST_HI; n_wait = 1'b1;
                end
            end
            S_TWIST_HI: begin
                if (!r_wait) begin
                    n_twisted = 1'b1;
                    n_angle = r_angle + frac;
                    if (tq > (72'd1 << 62)) begin
                        n_lift = tneg ? LIFT_MIN : LIFT_MAX; n_sat = 1'b1;
                    end else if (nl > 50'(LIFT_MAX)) begin
                        n_lift = LIFT_MAX; n_sat = 1'b1;
                    end else if (nl < 50'(LIFT_MIN)) begin
                        n_lift = LIFT_MIN; n_sat = 1'b1;
                    end else begin
                        n_lift = nl[47:0];
                    end
                    if (r_kicked) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CORDIC; n_wait = 1'b1;
                    end
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_valid;
    assign o_angle_out  = r_angle;
    assign o_action_out = r_action;
    assign o_lift_out   = r_lift;
    assign o_saturated  = r_sat;

    // no new transfer while a result is pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while result pending");
    // result stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_lift_out)))
        else $error("result dropped");
    // no transfer while the sequencer is working on an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives load, forward, inverse and unused-op items into the nontwist map
// step unit with random gaps and stalls, predicts each returned state in
// fixed point and checks it field by field
// ----------------------------------------------------------------------------
module testbench;
    import ntm_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] init_angle;
        logic [31:0] init_action;
        int          gap;
    } t_map_item;

    typedef struct {
        logic [23:0] angle;
        logic [31:0] action;
        logic [47:0] lift;
        logic        sat;
    } t_map_state;

    localparam longint LIFT_HI = (64'sd1 <<< 47) - 1;
    localparam longint LIFT_LO = -(64'sd1 <<< 47);
    localparam longint ONE_Q   = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF_Q  = 64'sd1 <<< (FRAC_BITS - 1);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = REG_TWIST;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = OP_LOAD;
    logic signed [31:0] i_init_angle = '0;
    logic signed [31:0] i_init_action = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [23:0] o_angle_out;
    logic signed [31:0] o_action_out;
    logic signed [47:0] o_lift_out;
    logic        o_saturated;

    nontwist_map_step_unit dut (.*);

    // predictor state and its copy of the gains
    longint    mdl_angle, mdl_action, mdl_lift, mdl_gain_a, mdl_gain_b;
    t_map_item  pending_items[$];
    t_map_state expected_states[$];
    int error_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit stall_mode = 1'b1;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // two's complement sign extend from width w
    function automatic longint sign_ext(longint v, int w);
        longint m;
        m = 64'sd1 <<< (w - 1);
        v = v & ((m <<< 1) - 1);
        return (v ^ m) - m;
    endfunction

    // sin(2 pi x) by rotation-mode cordic at 30 fraction bits
    function automatic longint cordic_sine(longint x);
        longint z, cx, cy, dx, dy, s;
        z  = x * (64'sd1 <<< (32 - FRAC_BITS));
        cx = CORDIC_GAIN_Q30;
        cy = 0;
        if (z >= (64'sd1 <<< 30)) z = (64'sd1 <<< 31) - z;
        else if (z < -(64'sd1 <<< 30)) z = -(64'sd1 <<< 31) - z;
        for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx; cy += dy; z -= longint'(atan_rev(i[4:0]));
            end else begin
                cx += dx; cy -= dy; z += longint'(atan_rev(i[4:0]));
            end
        end
        s = (cy + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (s > ONE_Q) s = ONE_Q;
        if (s < -ONE_Q) s = -ONE_Q;
        return s;
    endfunction

    // action update y += sgn * b*sin(2 pi x), saturating to 32 bits
    function automatic bit apply_kick(int sgn);
        longint k, ny;
        bit sat;
        sat = 1'b0;
        k  = (mdl_gain_b * cordic_sine(mdl_angle) + HALF_Q) >>> FRAC_BITS;
        ny = (sgn > 0) ? mdl_action + k : mdl_action - k;
        if (ny > 64'sd2147483647) begin ny = 64'sd2147483647; sat = 1'b1; end
        if (ny < -64'sd2147483648) begin ny = -64'sd2147483648; sat = 1'b1; end
        mdl_action = ny;
        return sat;
    endfunction

    // x and lift += sgn * a*(1-y^2); exact product in 128 bits
    function automatic bit apply_twist(int sgn);
        logic [63:0]  uy, y2, ua, uw, q, frac;
        logic [127:0] prod;
        longint w, nl;
        bit neg;
        uy = (mdl_action < 0) ? -mdl_action : mdl_action;
        y2 = (uy * uy + HALF_Q) >> FRAC_BITS;
        w  = ONE_Q - longint'(y2);
        neg = (mdl_gain_a < 0) != (w < 0);
        if (sgn < 0) neg = !neg;
        ua = (mdl_gain_a < 0) ? -mdl_gain_a : mdl_gain_a;
        uw = (w < 0) ? -w : w;
        prod = ({64'd0, ua} * {64'd0, uw} + HALF_Q) >> FRAC_BITS;
        q = prod[63:0];
        frac = q & (ONE_Q - 1);
        if (neg) frac = (-frac) & (ONE_Q - 1);
        mdl_angle = sign_ext(mdl_angle + longint'(frac), FRAC_BITS);
        if (prod[127:64] != 0 || q > (64'd1 << 62)) begin
            mdl_lift = neg ? LIFT_LO : LIFT_HI;
            return 1'b1;
        end
        nl = neg ? mdl_lift - longint'(q) : mdl_lift + longint'(q);
        if (nl > LIFT_HI) begin mdl_lift = LIFT_HI; return 1'b1; end
        if (nl < LIFT_LO) begin mdl_lift = LIFT_LO; return 1'b1; end
        mdl_lift = nl;
        return 1'b0;
    endfunction

    function automatic t_map_state predict_state(t_map_item it);
        t_map_state r;
        bit sat;
        sat = 1'b0;
        case (it.op)
            OP_LOAD: begin
                mdl_angle  = sign_ext(longint'(it.init_angle), FRAC_BITS);
                mdl_action = sign_ext(longint'(it.init_action), 32);
                mdl_lift   = mdl_angle;
            end
            OP_FORWARD: begin
                sat = apply_kick(-1);
                if (apply_twist(1)) sat = 1'b1;
            end
            OP_INVERSE: begin
                sat = apply_twist(-1);
                if (apply_kick(1)) sat = 1'b1;
            end
            default: ;
        endcase
        r.angle  = mdl_angle[23:0];
        r.action = mdl_action[31:0];
        r.lift   = mdl_lift[47:0];
        r.sat    = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // handshakes as seen at the rising edge, for the falling-edge blocks
    always @(posedge i_clk) begin
        in_taken  = i_rst_n && i_valid && o_ready;
        out_taken = i_rst_n && o_valid && i_ready;
    end

    // driver: one transfer per queued item after its gap; prediction at transfer
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                expected_states.push_back(predict_state(pending_items.pop_front()));
                if (pending_items.size() > 0) gap_left = pending_items[0].gap;
            end
            if ((!i_valid || in_taken) && pending_items.size() > 0 && gap_left == 0) begin
                i_valid       <= 1'b1;
                i_op          <= pending_items[0].op;
                i_init_angle  <= pending_items[0].init_angle;
                i_init_action <= pending_items[0].init_action;
            end else if (in_taken) begin
                i_valid <= 1'b0;
            end
            if (gap_left > 0 && !(i_valid && !in_taken)) gap_left--;
        end
    end

    // receiver stalls, redrawn after each result transfer
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) stall_left = stall_mode ? $urandom_range(0, 12) : 0;
            if (o_valid && stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_map_state e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_states.size() == 0) begin
                report_mismatch("unexpected result", {40'd0, o_angle_out}, 64'd0);
            end else begin
                e = expected_states.pop_front();
                if (o_angle_out !== e.angle)
                    report_mismatch("angle", {40'd0, o_angle_out}, {40'd0, e.angle});
                if (o_action_out !== e.action)
                    report_mismatch("action", {32'd0, o_action_out}, {32'd0, e.action});
                if (o_lift_out !== e.lift)
                    report_mismatch("lift", {16'd0, o_lift_out}, {16'd0, e.lift});
                if (o_saturated !== e.sat)
                    report_mismatch("saturated", {63'd0, o_saturated}, {63'd0, e.sat});
            end
        end
    end

    task automatic add_item(logic [1:0] op, logic [31:0] ang, logic [31:0] act);
        t_map_item it;
        it.op = op;
        it.init_angle = ang;
        it.init_action = act;
        it.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (pending_items.size() == 0) gap_left = it.gap;
        pending_items.push_back(it);
    endtask

    // wait until all items are transferred and every result is back
    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_states.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [0:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_TWIST) mdl_gain_a = sign_ext(longint'(val), 32);
        else mdl_gain_b = sign_ext(longint'(val), 32);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return OP_FORWARD;
        if (r < 85) return OP_INVERSE;
        if (r < 97) return OP_LOAD;
        return OP_UNUSED;
    endfunction

    // gains: half the time physical values, otherwise extremes or raw random
    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'(sign_ext($urandom_range(0, 32'h0200_0000), 26));
        endcase
    endfunction

    initial begin
        logic [31:0] ga, gb;
        mdl_angle = 0; mdl_action = 0; mdl_lift = 0;
        mdl_gain_a = 0; mdl_gain_b = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset state, loads at the wrap point, steps, unused op
        add_item(OP_FORWARD, 32'h0, 32'h0);
        add_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(OP_LOAD, 32'h0080_0000, 32'h0100_0000);
        drain();
        write_gain(REG_TWIST, 32'h0066_6666);
        write_gain(REG_KICK, 32'h0019_999A);
        add_item(OP_FORWARD, 32'h0, 32'h0);
        add_item(OP_INVERSE, 32'h0, 32'h0);
        add_item(OP_LOAD, 32'hFFFF_FFFF, 32'h8000_0000);
        add_item(OP_FORWARD, 32'h0, 32'h0);
        add_item(OP_INVERSE, 32'h0, 32'h0);
        add_item(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_item(OP_FORWARD, 32'h0, 32'h0);
        add_item(OP_LOAD, 32'h8000_0000, 32'h0);
        add_item(OP_INVERSE, 32'h0, 32'h0);
        add_item(OP_LOAD, 32'h0040_0000, 32'h0);
        add_item(OP_FORWARD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(OP_LOAD, 32'h00C0_0000, 32'h0);
        add_item(OP_INVERSE, 32'h0, 32'h0);
        drain();
        // extreme gains drive both saturations
        write_gain(REG_TWIST, 32'h7FFF_FFFF);
        write_gain(REG_KICK, 32'h8000_0000);
        add_item(OP_LOAD, 32'h0020_0000, 32'h7FFF_0000);
        repeat (3) add_item(OP_FORWARD, 32'h0, 32'h0);
        repeat (3) add_item(OP_INVERSE, 32'h0, 32'h0);
        drain();

        // random phases; each orbit starts with a load
        for (int ph = 0; ph < 13; ph++) begin
            ga = rand_gain();
            gb = rand_gain();
            write_gain(REG_TWIST, ga);
            write_gain(REG_KICK, gb);
            stall_mode = (ph % 4 != 3);
            for (int n = 0; n < 100; n++) begin
                if (n % 25 == 0)
                    add_item(OP_LOAD, $urandom,
                             ($urandom_range(0, 3) == 0) ? $urandom
                                 : 32'(sign_ext($urandom_range(0, 32'h0400_0000), 27)));
                else
                    add_item(rand_op(), $urandom, $urandom);
                if (ph == 5 && n == 50) drain();
            end
            drain();
        end
        if (error_count == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== nontwist_map_step_unit.f =====
rtl/ntm_pkg.sv
rtl/ntm_cordic.sv
rtl/ntm_mul.sv
rtl/nontwist_map_step_unit.sv
sim/testbench.sv
